>>> sv/prle_pkg.sv
// shared types and constants for the palette run-length encoder
// no dependencies; compile first

package prle_pkg;

  localparam int COLOR_W    = 24;
  localparam int LEN_W      = 11;
  localparam int IDX_W      = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // word index of each configuration register (paddr[2])
  localparam logic REG_BACKGROUND = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic [IDX_W-1:0] color_index;
    logic             last_of_line;
    logic             palette_overflow;
  } run_t;

endpackage

>>> sv/prle_pix_if.sv
// pixel item channel: valid/ready plus pixel payload
// depends on prle_pkg

interface prle_pix_if;
  import prle_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               end_of_line;
  logic               start_of_image;

  modport source (output valid, pixel_color, end_of_line, start_of_image, input ready);
  modport sink   (input valid, pixel_color, end_of_line, start_of_image, output ready);
endinterface

>>> sv/prle_run_if.sv
// run item channel: valid/ready plus encoded run payload
// depends on prle_pkg

interface prle_run_if;
  import prle_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] run_length;
  logic [IDX_W-1:0] color_index;
  logic             last_of_line;
  logic             palette_overflow;

  modport source (output valid, run_length, color_index, last_of_line, palette_overflow,
                  input ready);
  modport sink   (input valid, run_length, color_index, last_of_line, palette_overflow,
                  output ready);
endinterface

>>> sv/palette_run_length_encoder.sv
// top level of the palette run-length encoder: input register, run tracker, config port
// depends on prle_pkg, prle_pix_if, prle_run_if, prle_palette, prle_out_fifo
//
// usage:
//   in_ch carries one pixel item per handshake (valid/ready): 24-bit color, end_of_line
//   on the last pixel of a row or column, start_of_image on the first pixel of a frame
//   (clears the palette and drops any open run before that pixel is used).
//   out_ch carries run items: length, palette index, last_of_line, palette_overflow.
//   an item may produce zero, one or two runs (closed run, then the line-end run).
//   the APB port holds background_color at byte address 0; write only while idle.
// timing:
//   a pixel is held in the input register, where the palette compare and the run
//   counter update are combinational; its runs are registered into a four-entry queue
//   and appear on out_ch behind any runs already waiting there.
//   one pixel per cycle sustained while out_ch does not stall; the input register
//   drains only with two free queue slots, as a line end that closes a run pushes two runs.
// reset and stall:
//   rst_n (synchronous) empties the queue, clears the run, sets background to zero and
//   the palette to background only. when out_ch stalls the queue fills and in_ch.ready
//   drops after at most a few items; nothing is lost.

module palette_run_length_encoder #(
  parameter int PALETTE_DEPTH = 32,
  parameter int MAX_LINE      = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  prle_pix_if.sink                        in_ch,
  prle_run_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prle_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [prle_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [prle_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import prle_pkg::*;

  localparam int PIW = $clog2(PALETTE_DEPTH);
  localparam int RCW = $clog2(MAX_LINE + 1);

  // config register
  logic [COLOR_W-1:0] bg_r;

  // input register
  logic               stg_vld_r;
  logic [COLOR_W-1:0] stg_pix_r;
  logic               stg_eol_r;
  logic               stg_soi_r;

  // open run
  logic [RCW-1:0]     run_cnt_r, run_cnt_nxt;
  logic [COLOR_W-1:0] run_col_r, run_col_nxt;
  logic [PIW-1:0]     run_idx_r, run_idx_nxt;

  logic               adv, room;
  logic [RCW-1:0]     cnt_eff, cnt_after;
  logic [COLOR_W-1:0] col_eff;
  logic [PIW-1:0]     idx_eff, idx_after, pal_idx;
  logic               extend, close_prev, pal_ovf;
  logic               push0, push1;
  run_t               res_close, res_eol;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BACKGROUND) ? CFG_DATA_W'(bg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BACKGROUND) begin
      bg_r <= pwdata[COLOR_W-1:0];
    end
  end

  // ---------------------------------------------------------------- input register
  // drains whenever the queue has space for the worst case of two runs
  assign adv         = stg_vld_r && room;
  assign in_ch.ready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_pix_r <= in_ch.pixel_color;
      stg_eol_r <= in_ch.end_of_line;
      stg_soi_r <= in_ch.start_of_image;
    end
  end

  // ---------------------------------------------------------------- run tracking
  prle_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (adv && stg_soi_r),
    .look     (adv && !extend),
    .color    (stg_pix_r),
    .bg       (bg_r),
    .index    (pal_idx),
    .overflow (pal_ovf)
  );

  always_comb begin
    // start of image drops the open run before this pixel
    cnt_eff = stg_soi_r ? '0 : run_cnt_r;
    col_eff = stg_soi_r ? '0 : run_col_r;
    idx_eff = stg_soi_r ? '0 : run_idx_r;

    // same color continues the run until it reaches the line limit
    extend     = (cnt_eff != '0) && (stg_pix_r == col_eff) && (cnt_eff < RCW'(MAX_LINE));
    close_prev = !extend && (cnt_eff != '0) && (col_eff != bg_r);

    cnt_after = extend ? cnt_eff + RCW'(1) : RCW'(1);
    idx_after = extend ? idx_eff : pal_idx;

    res_close.run_length       = LEN_W'(cnt_eff);
    res_close.color_index      = IDX_W'(idx_eff);
    res_close.last_of_line     = 1'b0;
    res_close.palette_overflow = pal_ovf;

    // line end: the final run, or an empty marker when the line ends in background
    if (stg_pix_r != bg_r) begin
      res_eol.run_length  = LEN_W'(cnt_after);
      res_eol.color_index = IDX_W'(idx_after);
    end else begin
      res_eol.run_length  = '0;
      res_eol.color_index = '0;
    end
    res_eol.last_of_line     = 1'b1;
    res_eol.palette_overflow = pal_ovf;

    if (stg_eol_r) begin
      run_cnt_nxt = '0;
      run_col_nxt = '0;
      run_idx_nxt = '0;
    end else begin
      run_cnt_nxt = cnt_after;
      run_col_nxt = stg_pix_r;
      run_idx_nxt = idx_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
      run_col_r <= '0;
      run_idx_r <= '0;
    end else if (adv) begin
      run_cnt_r <= run_cnt_nxt;
      run_col_r <= run_col_nxt;
      run_idx_r <= run_idx_nxt;
    end
  end

  // ---------------------------------------------------------------- result queue
  assign push0 = adv && (close_prev || stg_eol_r);
  assign push1 = adv && close_prev && stg_eol_r;

  prle_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push0  (push0),
    .push1  (push1),
    .d0     (close_prev ? res_close : res_eol),
    .d1     (res_eol),
    .room   (room),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------- checks
  a_empty_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.run_length == '0 |-> out_ch.last_of_line)
    else $error("zero-length run not marked last");

  a_line_end_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stg_eol_r |=> run_cnt_r == '0)
    else $error("open run survives line end");

  a_second_push_needs_eol: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0 && stg_eol_r)
    else $error("second result without line end");

  a_run_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= RCW'(MAX_LINE))
    else $error("run count beyond line limit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stg_vld_r && !room)
    else $error("input stalled with free input register");

endmodule

>>> sv/prle_palette.sv
// color palette: parallel compare against all live entries, in-order allocation
// depends on prle_pkg

module prle_palette #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         look,
  input  logic [prle_pkg::COLOR_W-1:0] color,
  input  logic [prle_pkg::COLOR_W-1:0] bg,
  output logic [$clog2(DEPTH)-1:0]     index,
  output logic                         overflow
);
  import prle_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [COLOR_W-1:0] ent_r [DEPTH];
  logic [CW-1:0]      cnt_r, cnt_nxt, cnt_eff;
  logic               ovf_r;
  logic [DEPTH-1:0]   match;
  logic [IW-1:0]      hit_idx;
  logic               alloc, miss_full;

  always_comb begin
    cnt_eff = clear ? CW'(1) : cnt_r;
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (i != 0) && (CW'(i) < cnt_eff) && (ent_r[i] == color);
      if (match[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  always_comb begin
    index     = '0;
    alloc     = 1'b0;
    miss_full = 1'b0;
    priority if (color == bg) begin
      index = '0;
    end else if (|match) begin
      index = hit_idx;
    end else if (cnt_eff < CW'(DEPTH)) begin
      index = cnt_eff[IW-1:0];
      alloc = 1'b1;
    end else begin
      miss_full = 1'b1;
    end
    cnt_nxt  = (look && alloc) ? cnt_eff + CW'(1) : cnt_eff;
    overflow = (clear ? 1'b0 : ovf_r) | (look & miss_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(1);
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (look && alloc) ent_r[cnt_eff[IW-1:0]] <= color;
  end

endmodule

>>> sv/prle_out_fifo.sv
// four-entry result queue, up to two pushes and one pop per cycle
// depends on prle_pkg and prle_run_if

module prle_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push0,
  input  logic           push1,
  input  prle_pkg::run_t d0,
  input  prle_pkg::run_t d1,
  output logic           room,
  prle_run_if.source     out_ch
);
  import prle_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  run_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = cnt_r <= CW'(DEPTH - 2);

  assign out_ch.valid            = cnt_r != '0;
  assign out_ch.run_length       = mem_r[rd_ptr_r].run_length;
  assign out_ch.color_index      = mem_r[rd_ptr_r].color_index;
  assign out_ch.last_of_line     = mem_r[rd_ptr_r].last_of_line;
  assign out_ch.palette_overflow = mem_r[rd_ptr_r].palette_overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push0) + AW'(push1);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      cnt_r    <= cnt_r + CW'(push0) + CW'(push1) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) mem_r[wr_ptr_r] <= d0;
    if (push1) mem_r[wr_ptr_r + AW'(1)] <= d1;
  end

endmodule

>>> sim/prle_encoder_checker.sv
// run checker for the palette run-length encoder: watches both item channels and the
// config port, predicts the runs of every accepted pixel and compares them in order
// depends on prle_pkg, prle_pix_if, prle_run_if

module prle_encoder_checker #(
  parameter int PALETTE_DEPTH = 32,
  parameter int MAX_LINE      = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  prle_pix_if                             pix,
  prle_run_if                             runs,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prle_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [prle_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              outstanding,
  output int                              runs_checked,
  output int                              overflow_runs,
  output int                              full_runs
);
  timeunit 1ns;
  timeprecision 1ps;
  import prle_pkg::*;

  logic [COLOR_W-1:0] palette_tbl [PALETTE_DEPTH];
  int                 palette_used;
  logic [COLOR_W-1:0] bg_color;
  logic [COLOR_W-1:0] open_color;
  logic [LEN_W-1:0]   open_len;
  logic [IDX_W-1:0]   open_idx;
  logic               overflow_flag;
  run_t               expected_runs [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_palette();
    for (int i = 0; i < PALETTE_DEPTH; i++) palette_tbl[i] = '0;
    palette_tbl[0] = bg_color;
    palette_used   = 1;
    overflow_flag  = 1'b0;
  endtask

  // background first, then known entries, then a fresh entry if one is free
  task automatic assign_index(input logic [COLOR_W-1:0] c, output logic [IDX_W-1:0] idx);
    idx = '0;
    if (c == bg_color) return;
    for (int i = 1; i < palette_used; i++) begin
      if (palette_tbl[i] == c) begin
        idx = IDX_W'(i);
        return;
      end
    end
    if (palette_used < PALETTE_DEPTH) begin
      palette_tbl[palette_used] = c;
      idx = IDX_W'(palette_used);
      palette_used++;
    end else begin
      overflow_flag = 1'b1;
    end
  endtask

  task automatic predict_runs(input logic [COLOR_W-1:0] c, input logic eol, input logic soi);
    run_t staged [2];
    int   n;
    n = 0;
    if (soi) begin
      clear_palette();
      open_len   = '0;
      open_color = '0;
      open_idx   = '0;
    end
    if (open_len > 0 && c == open_color && open_len < MAX_LINE) begin
      open_len++;
    end else begin
      if (open_len > 0 && open_color != bg_color) begin
        staged[n] = '{run_length: open_len, color_index: open_idx,
                      last_of_line: 1'b0, palette_overflow: 1'b0};
        n++;
      end
      open_color = c;
      open_len   = LEN_W'(1);
      assign_index(c, open_idx);
    end
    if (eol) begin
      if (open_color != bg_color)
        staged[n] = '{run_length: open_len, color_index: open_idx,
                      last_of_line: 1'b1, palette_overflow: 1'b0};
      else
        staged[n] = '{run_length: '0, color_index: '0,
                      last_of_line: 1'b1, palette_overflow: 1'b0};
      n++;
      open_len   = '0;
      open_color = '0;
      open_idx   = '0;
    end
    // overflow flag is the one left after this pixel, on every run it causes
    for (int k = 0; k < n; k++) begin
      staged[k].palette_overflow = overflow_flag;
      expected_runs.insert(expected_runs.size(), staged[k]);
    end
  endtask

  task automatic check_run();
    run_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch($sformatf("run len %0d idx %0d with no pixel behind it",
                                runs.run_length, runs.color_index));
      return;
    end
    want = expected_runs.pop_front();
    runs_checked++;
    if (want.palette_overflow) overflow_runs++;
    if (want.run_length == MAX_LINE) full_runs++;
    if (runs.run_length !== want.run_length)
      report_mismatch($sformatf("run_length got %0d want %0d",
                                runs.run_length, want.run_length));
    if (runs.color_index !== want.color_index)
      report_mismatch($sformatf("color_index got %0d want %0d",
                                runs.color_index, want.color_index));
    if (runs.last_of_line !== want.last_of_line)
      report_mismatch($sformatf("last_of_line got %b want %b",
                                runs.last_of_line, want.last_of_line));
    if (runs.palette_overflow !== want.palette_overflow)
      report_mismatch($sformatf("palette_overflow got %b want %b",
                                runs.palette_overflow, want.palette_overflow));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bg_color      = '0;
      clear_palette();
      open_len      = '0;
      open_color    = '0;
      open_idx      = '0;
      expected_runs.delete();
      fail_count    = 0;
      runs_checked  = 0;
      overflow_runs = 0;
      full_runs     = 0;
      outstanding  <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_BACKGROUND) begin
        bg_color       = pwdata[COLOR_W-1:0];
        palette_tbl[0] = bg_color;
      end
      if (runs.valid && runs.ready) check_run();
      if (pix.valid && pix.ready)
        predict_runs(pix.pixel_color, pix.end_of_line, pix.start_of_image);
      outstanding <= expected_runs.size();
    end
  end

endmodule

>>> sim/testbench.sv
// top of the palette run-length encoder bench: clock, reset, pixel and config stimulus,
// receiver stalls and the verdict; prediction and compare live in prle_encoder_checker
// depends on prle_pkg, prle_pix_if, prle_run_if, palette_run_length_encoder, the checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prle_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_PIXELS = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  prle_pix_if pix ();
  prle_run_if runs ();

  int fail_count;
  int outstanding;
  int runs_checked;
  int overflow_runs;
  int full_runs;

  // stimulus knobs: sender gap and receiver stall chance in percent
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;

  int                 pixels_sent;
  int                 images_sent;
  int                 bg_writes;
  logic [COLOR_W-1:0] bg_now;

  palette_run_length_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix),
    .out_ch  (runs),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  prle_encoder_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix           (pix),
    .runs          (runs),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .runs_checked  (runs_checked),
    .overflow_runs (overflow_runs),
    .full_runs     (full_runs)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one;
  // the hold-off is counted here so the sender keeps pushing while the block fills up
  initial begin
    int seen;
    int left;
    seen = 0;
    left = 0;
    runs.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        runs.ready <= 1'b0;
        left--;
      end else begin
        runs.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one pixel item: optional idle gap, then hold valid until the handshake
  task automatic send_pixel(input logic [COLOR_W-1:0] c, input logic eol, input logic soi);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid          <= 1'b1;
    pix.pixel_color    <= c;
    pix.end_of_line    <= eol;
    pix.start_of_image <= soi;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // stop sending and wait for every predicted run, then let the input register empty
  // out, since a pixel that causes no run may still sit in it
  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the background register: setup cycle, then access cycle
  task automatic write_background(input logic [COLOR_W-1:0] c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({REG_BACKGROUND, 2'b00});
    pwdata  <= CFG_DATA_W'(c);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bg_now = c;
    bg_writes++;
  endtask

  // one random image: runs of random length drawn from a random-size color pool with
  // plenty of background; big pools over many lines run the palette out of entries.
  // a stray start of image or a missing one at the first pixel stands in for noise
  task automatic send_image();
    logic [COLOR_W-1:0] pool [48];
    logic [COLOR_W-1:0] c;
    int                 n_colors;
    int                 lines;
    int                 line_len;
    int                 run_left;
    logic               soi;
    n_colors = $urandom_range(2, 48);
    lines    = $urandom_range(1, 6);
    c        = bg_now;
    for (int i = 0; i < 48; i++) pool[i] = COLOR_W'($urandom);
    images_sent++;
    for (int l = 0; l < lines; l++) begin
      line_len = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      run_left = 0;
      for (int i = 0; i < line_len; i++) begin
        if (run_left == 0) begin
          c        = ($urandom_range(99) < 30) ? bg_now : pool[$urandom_range(n_colors - 1)];
          run_left = $urandom_range(1, 5);
        end
        if (l == 0 && i == 0) soi = ($urandom_range(9) != 0);
        else                  soi = ($urandom_range(199) == 0);
        send_pixel(c, i == line_len - 1, soi);
        run_left--;
      end
      // now and then the sender waits for the block to empty mid image
      if ($urandom_range(24) == 0) wait_drained();
    end
  endtask

  initial begin
    int start;
    rst_n              <= 1'b0;
    pix.valid          <= 1'b0;
    pix.pixel_color    <= '0;
    pix.end_of_line    <= 1'b0;
    pix.start_of_image <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    recv_stall_pct     <= 0;
    hold_requests      <= 0;
    send_idle_pct  = 0;
    pixels_sent    = 0;
    images_sent    = 0;
    bg_writes      = 0;
    bg_now         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, background black from reset ---
    // two-pixel run, a one-pixel run closed by background, and a background line end,
    // which gives two runs for one pixel
    send_pixel(24'h000001, 1'b0, 1'b1);
    send_pixel(24'h000001, 1'b0, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 1'b0);
    send_pixel(24'h000000, 1'b1, 1'b0);
    // line of one colored pixel, then a line of one background pixel
    send_pixel(24'h123456, 1'b1, 1'b0);
    send_pixel(24'h000000, 1'b1, 1'b0);
    // start of image in mid line drops the open run and restarts the palette
    send_pixel(24'hABCDEF, 1'b0, 1'b0);
    send_pixel(24'hABCDEF, 1'b0, 1'b1);
    send_pixel(24'h800000, 1'b1, 1'b0);
    // start of image and line end on the same pixel
    send_pixel(24'h7FFFFF, 1'b1, 1'b1);
    wait_drained();

    // background switched to a color already in the palette: it becomes index 0,
    // and the old background now needs an entry of its own
    write_background(24'h7FFFFF);
    send_pixel(24'h7FFFFF, 1'b1, 1'b0);
    send_pixel(24'h000000, 1'b0, 1'b0);
    send_pixel(24'h000000, 1'b1, 1'b0);

    // palette full: 33 new colors in one image, then a line after the overflow, then
    // a start of image that clears the flag again
    for (int i = 1; i <= 33; i++)
      send_pixel(COLOR_W'(i * 24'h010203), i == 33, i == 1);
    send_pixel(24'h0A0F14, 1'b1, 1'b0);
    send_pixel(24'h0A0F14, 1'b1, 1'b1);

    // --- random part: idling phases, each with its own background ---
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      unique case (phase)
        0: begin
          send_idle_pct   = 0;
          recv_stall_pct <= 0;
          write_background(24'hFFFFFF);
        end
        1: begin
          send_idle_pct   = 85;
          recv_stall_pct <= 0;
          write_background(COLOR_W'($urandom));
        end
        2: begin
          send_idle_pct   = 0;
          recv_stall_pct <= 85;
          write_background(24'h000000);
        end
        default: begin
          send_idle_pct   = 11;
          recv_stall_pct <= 11;
          write_background(COLOR_W'($urandom));
        end
      endcase
      // long receiver hold-off while pixels keep coming, so the input stalls
      if (phase == 0 || phase == 3) hold_requests <= hold_requests + 1;
      start = pixels_sent;
      while (pixels_sent - start < PHASE_PIXELS) send_image();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d pixels (%0d random images) under %0d background settings",
             pixels_sent, images_sent, bg_writes);
    $display("checked %0d runs, %0d flagged palette overflow, %0d at the length limit",
             runs_checked, overflow_runs, full_runs);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
